// ----- hdl/sorted_key_table_core_assert.svh -----
// assertion macros for the sorted key table core
// used by the top level only, no other dependencies
`ifndef SORTED_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SKT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(label, clk, rst_n, prop, msg)
`define SKT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hdl/skt_pkg.sv -----
// shared constants and types for the sorted key table core
// no dependencies
`timescale 1ns / 1ps

package skt_pkg;

	localparam int CAPACITY = 16;
	localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam int KEY_W    = 64;
	localparam int AGE_W    = 8;
	localparam int RIDX_W   = 4;
	localparam int CNT_W    = 5;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 80;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} entry_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} cmd_t;

	// compare results of one cell against the broadcast key
	typedef struct packed {
		logic gt;
		logic ge;
		logic eq;
	} flags_t;

endpackage

// ----- hdl/sorted_key_table_core.sv -----
// sorted key table: an accepted transaction is registered and raises m_tvalid in the next cycle;
// throughput one transaction per cycle while m_tready stays high
// every cell compares and shifts in the same cycle, so the row update sets the rate
// arst_n clears the entry count and the output valid; cell contents are undefined
// until written and are never read beyond the count
`timescale 1ns / 1ps
`include "sorted_key_table_core_assert.svh"

module sorted_key_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [skt_pkg::KIND_W-1:0]      s_tuser,  // kind
	input  logic [skt_pkg::S_TDATA_W-1:0]   s_tdata,  // name_key, age, read_index, zero pad
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [skt_pkg::STAT_W-1:0]      m_tuser,  // status
	output logic [skt_pkg::M_TDATA_W-1:0]   m_tdata   // out_key, out_age, count, zero pad
);

	localparam int N = skt_pkg::CAPACITY;

	// input fields
	logic [skt_pkg::KEY_W-1:0]  in_key;
	logic [skt_pkg::AGE_W-1:0]  in_age;
	logic [skt_pkg::RIDX_W-1:0] in_ridx;

	assign in_key  = s_tdata[skt_pkg::KEY_W-1:0];
	assign in_age  = s_tdata[skt_pkg::KEY_W +: skt_pkg::AGE_W];
	assign in_ridx = s_tdata[skt_pkg::KEY_W + skt_pkg::AGE_W +: skt_pkg::RIDX_W];

	// control state
	logic [skt_pkg::CNT_W-1:0] count_q;
	logic                      m_valid_q;

	// output register
	logic [skt_pkg::STAT_W-1:0] status_q;
	logic [skt_pkg::KEY_W-1:0]  out_key_q;
	logic [skt_pkg::AGE_W-1:0]  out_age_q;
	logic [skt_pkg::CNT_W-1:0]  out_cnt_q;

	logic accept;
	logic is_ins, is_del, is_rd;
	logic full;
	logic found;
	logic rd_ok;

	skt_pkg::cmd_t                 cmd;
	skt_pkg::entry_t [N-1:0]       cell_ent;
	skt_pkg::flags_t [N-1:0]       cell_flags;
	logic [N-1:0]                  cell_valid;
	logic [N-1:0]                  eq_vec;
	logic [skt_pkg::POS_W-1:0]     rd_pos;

	logic [skt_pkg::CNT_W-1:0]     count_nxt;
	logic [skt_pkg::STAT_W-1:0]    status_nxt;
	logic [skt_pkg::KEY_W-1:0]     rd_key;
	logic [skt_pkg::AGE_W-1:0]     rd_age;

	// a new transaction enters while the result slot is empty or being drained
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign is_ins = (s_tuser == skt_pkg::KIND_INSERT);
	assign is_del = (s_tuser == skt_pkg::KIND_DELETE);
	assign is_rd  = (s_tuser == skt_pkg::KIND_READ);
	assign full   = (count_q >= skt_pkg::CNT_CAP);

	// equal keys sit together, so any match means the first key >= k is the one to drop
	assign found = |eq_vec;

	always_comb begin
		cmd.ins_en = accept && is_ins && !full;
		cmd.del_en = accept && is_del && found;
		cmd.key    = in_key;
		cmd.age    = in_age;
	end

	// row of cells, each shifting with its neighbors
	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			skt_pkg::entry_t left_ent;
			skt_pkg::entry_t right_ent;
			logic            left_gt;

			assign cell_valid[gi] = (skt_pkg::CNT_W'(gi) < count_q);
			assign eq_vec[gi]     = cell_flags[gi].eq;

			if (gi == 0) begin : g_first
				assign left_gt  = 1'b0;
				assign left_ent = cell_ent[gi];
			end else begin : g_mid
				assign left_gt  = cell_flags[gi-1].gt;
				assign left_ent = cell_ent[gi-1];
			end

			// the last cell refills with itself; it lies past the count after a delete
			if (gi == N-1) begin : g_last
				assign right_ent = cell_ent[gi];
			end else begin : g_inner
				assign right_ent = cell_ent[gi+1];
			end

			skt_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.valid     (cell_valid[gi]),
				.left_gt   (left_gt),
				.left_ent  (left_ent),
				.right_ent (right_ent),
				.ent       (cell_ent[gi]),
				.flags     (cell_flags[gi])
			);
		end
	endgenerate

	// read port: bound check against the count on the full index
	assign rd_ok  = ({1'b0, in_ridx} < count_q);
	assign rd_pos = skt_pkg::POS_W'(in_ridx);

	always_comb begin
		rd_key     = '0;
		rd_age     = '0;
		status_nxt = skt_pkg::ST_OK;
		count_nxt  = count_q;
		if (is_ins) begin
			if (full) begin
				status_nxt = skt_pkg::ST_FULL;
			end else begin
				count_nxt = count_q + skt_pkg::CNT_W'(1);
			end
		end else if (is_del) begin
			if (found) begin
				count_nxt = count_q - skt_pkg::CNT_W'(1);
			end else begin
				status_nxt = skt_pkg::ST_NOT_FOUND;
			end
		end else if (is_rd) begin
			if (rd_ok) begin
				rd_key = cell_ent[rd_pos].key;
				rd_age = cell_ent[rd_pos].age;
			end else begin
				status_nxt = skt_pkg::ST_BAD_INDEX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			out_key_q <= rd_key;
			out_age_q <= rd_age;
			out_cnt_q <= count_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {
		(skt_pkg::M_TDATA_W - skt_pkg::KEY_W - skt_pkg::AGE_W - skt_pkg::CNT_W)'(0),
		out_cnt_q, out_age_q, out_key_q
	};

	// checks; the count is unknown until the first clock under reset
	`SKT_ASSERT_ALWAYS(a_count_bound, clk,
		!arst_n || count_q <= skt_pkg::CNT_CAP, "entry count above capacity")
	`SKT_ASSERT(a_ins_grows, clk, arst_n,
		cmd.ins_en |=> count_q == $past(count_q) + skt_pkg::CNT_W'(1),
		"insert did not grow the count")
	`SKT_ASSERT(a_full_status, clk, arst_n,
		accept && is_ins && full |=> m_tvalid && m_tuser == skt_pkg::ST_FULL && $stable(count_q),
		"insert into full table not reported")
	`SKT_ASSERT(a_miss_keeps, clk, arst_n,
		accept && is_del && !found |=> m_tuser == skt_pkg::ST_NOT_FOUND && $stable(count_q),
		"missed delete changed the table")

endmodule

// ----- hdl/skt_cell.sv -----
// one position of the sorted row: holds an entry, compares, shifts
// depends on skt_pkg
`timescale 1ns / 1ps

module skt_cell (
	input  logic            clk,
	input  skt_pkg::cmd_t   cmd,
	input  logic            valid,     // position below the entry count
	input  logic            left_gt,   // left neighbor holds a greater key or is empty
	input  skt_pkg::entry_t left_ent,
	input  skt_pkg::entry_t right_ent,
	output skt_pkg::entry_t ent,
	output skt_pkg::flags_t flags
);

	skt_pkg::entry_t ent_q;

	// empty positions count as greater so the insert point is monotonic
	always_comb begin
		flags.gt = !valid || (ent_q.key > cmd.key);
		flags.ge = valid && (ent_q.key >= cmd.key);
		flags.eq = valid && (ent_q.key == cmd.key);
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (flags.gt && !left_gt) begin
				ent_q.key <= cmd.key;
				ent_q.age <= cmd.age;
			end else if (flags.gt) begin
				ent_q <= left_ent;
			end
		end else if (cmd.del_en && flags.ge) begin
			ent_q <= right_ent;
		end
	end

	assign ent = ent_q;

endmodule

// ----- bench/tb_sorted_key_table_core.sv -----
// self-checking bench for sorted_key_table_core: directed and random insert, delete and read
// transactions checked against an in-bench sorted table predictor; needs skt_pkg and the core
`timescale 1ns / 1ps

module tb_sorted_key_table_core;

	import skt_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT  = 2000; // cycles with no transaction on either side
	localparam int DRAIN_CYCLES = 8;    // core output is registered, allow some slack
	localparam int MAX_PRINT    = 100;
	localparam int POOL_SIZE    = 9;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  key;
		logic [AGE_W-1:0]  age;
		logic [CNT_W-1:0]  count;
	} table_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [KIND_W-1:0]    s_tuser  = '0;  // kind
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // name_key, age, read_index, zero pad
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [STAT_W-1:0]    m_tuser;        // status
	logic [M_TDATA_W-1:0] m_tdata;        // out_key, out_age, count, zero pad

	sorted_key_table_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the table
	logic [KEY_W-1:0] held_keys [CAPACITY];
	logic [AGE_W-1:0] held_ages [CAPACITY];
	int               held_count = 0;

	table_result_t    pending_results [$];
	logic [KEY_W-1:0] name_pool [POOL_SIZE];

	int error_count = 0;
	int kind_seen [4];
	int status_seen [4];
	int peak_count = 0;
	int burst_left = 0;

	// apply one operation to the predictor table and return what the core should answer
	function automatic table_result_t apply_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [AGE_W-1:0] age, logic [RIDX_W-1:0] idx);
		table_result_t res;
		int pos;
		res = '0;
		res.status = ST_OK;
		case (kind)
			KIND_INSERT: begin
				if (held_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// first strictly greater key, so equal keys stay in arrival order
					pos = held_count;
					for (int i = 0; i < held_count; i++) begin
						if (held_keys[i] > key) begin
							pos = i;
							break;
						end
					end
					for (int i = held_count; i > pos; i--) begin
						held_keys[i] = held_keys[i-1];
						held_ages[i] = held_ages[i-1];
					end
					held_keys[pos] = key;
					held_ages[pos] = age;
					held_count++;
				end
			end
			KIND_DELETE: begin
				pos = held_count;
				for (int i = 0; i < held_count; i++) begin
					if (held_keys[i] == key) begin
						pos = i;
						break;
					end
				end
				if (pos >= held_count) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < held_count; i++) begin
						held_keys[i] = held_keys[i+1];
						held_ages[i] = held_ages[i+1];
					end
					held_count--;
				end
			end
			KIND_READ: begin
				if (idx < held_count) begin
					res.key = held_keys[idx];
					res.age = held_ages[idx];
				end else begin
					res.status = ST_BAD_INDEX;
				end
			end
			default: begin
				// unused kind: table untouched, plain ok with the count
			end
		endcase
		res.count = CNT_W'(held_count);
		return res;
	endfunction

	// eight characters, big-endian, zero padded
	function automatic logic [KEY_W-1:0] pack_name(string s);
		logic [KEY_W-1:0] k;
		k = '0;
		for (int i = 0; i < 8; i++)
			k = {k[KEY_W-9:0], (i < s.len()) ? s[i] : 8'h00};
		return k;
	endfunction

	task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		if (error_count < MAX_PRINT)
			$display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// checker and predictor; both read values as they were before this edge
	always @(posedge clk) begin : monitor
		table_result_t got;
		table_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.key    = m_tdata[63:0];
				got.age    = m_tdata[71:64];
				got.count  = m_tdata[76:72];
				if (pending_results.size() == 0) begin
					report_mismatch("result with no pending transaction", got.key, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.key !== want.key)
						report_mismatch("out_key", got.key, want.key);
					if (got.age !== want.age)
						report_mismatch("out_age", 64'(got.age), 64'(want.age));
					if (got.count !== want.count)
						report_mismatch("count", 64'(got.count), 64'(want.count));
					if (m_tdata[79:77] !== 3'b000)
						report_mismatch("m_tdata pad", 64'(m_tdata[79:77]), '0);
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_op(s_tuser, s_tdata[63:0], s_tdata[71:64], s_tdata[75:72]);
				pending_results.push_back(want);
				kind_seen[s_tuser]++;
				status_seen[want.status]++;
				if (held_count > peak_count)
					peak_count = held_count;
			end
		end
	end

	// watchdog: ends the run if neither side moves a transaction for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver backpressure: switches between always ready, random stalls and periodic stalls
	int  stall_mode = 0;
	int  mode_left = 0;
	int  phase_left = 0;
	logic ready_phase = 1'b1;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(32, 200);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (phase_left == 0) begin
					ready_phase = !ready_phase;
					phase_left  = ready_phase ? $urandom_range(1, 6) : $urandom_range(1, 12);
				end
				phase_left--;
				m_tready <= ready_phase;
			end
		endcase
	end

	// sender pacing: bursts of random length, random gaps, ends at a falling edge
	task automatic next_slot();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
	endtask

	// drive one transaction at the current falling edge and hold it until accepted
	task automatic send_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [AGE_W-1:0] age, logic [RIDX_W-1:0] idx);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0000, idx, age, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic issue(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [AGE_W-1:0] age, logic [RIDX_W-1:0] idx);
		next_slot();
		send_op(kind, key, age, idx);
	endtask

	// sender holds off until every pending result has come back
	task automatic drain_wait();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [KEY_W-1:0] held_key_any();
		return held_keys[$urandom_range(0, held_count - 1)];
	endfunction

	task automatic test_empty_table();
		issue(KIND_READ, '0, 8'd0, 4'd0);
		issue(KIND_READ, '1, 8'hFF, 4'd15);
		issue(KIND_DELETE, pack_name("alice"), 8'd0, 4'd0);
		issue(KIND_UNUSED, rand_key(), 8'($urandom()), 4'($urandom()));
	endtask

	task automatic test_order_and_duplicates();
		issue(KIND_INSERT, pack_name("bob"), 8'd30, 4'd0);
		issue(KIND_INSERT, '0, 8'd0, 4'd0);
		issue(KIND_INSERT, '1, 8'hFF, 4'hF);
		issue(KIND_INSERT, pack_name("bob"), 8'd31, 4'd0);    // equal key goes after
		issue(KIND_INSERT, pack_name("alice"), 8'd200, 4'd0);
		issue(KIND_INSERT, pack_name("bobby"), 8'd7, 4'd0);   // shared prefix
		for (int i = 0; i < 6; i++)
			issue(KIND_READ, '0, 8'd0, 4'(i));
		issue(KIND_READ, '0, 8'd0, 4'd6);                     // index equal to count
		issue(KIND_DELETE, pack_name("bob"), 8'd0, 4'd0);     // first of the equal pair
		issue(KIND_READ, '0, 8'd0, 4'd2);
		issue(KIND_DELETE, pack_name("carol"), 8'd0, 4'd0);
		issue(KIND_DELETE, '1, 8'd0, 4'd0);                   // last entry, nothing to move
		issue(KIND_DELETE, '0, 8'd0, 4'd0);                   // first entry
		issue(KIND_UNUSED, '0, 8'd0, 4'd0);
	endtask

	// starts with the table settled, so the number of inserts to fill it is known up front
	task automatic test_full_table();
		bit fill_pool;
		int fill_left;
		fill_left = CAPACITY - held_count;
		repeat (fill_left) begin
			next_slot();
			fill_pool = 1'($urandom_range(0, 1));
			send_op(KIND_INSERT, fill_pool ? name_pool[$urandom_range(0, POOL_SIZE - 1)]
				: rand_key(), 8'($urandom()), 4'($urandom()));
		end
		issue(KIND_INSERT, '0, 8'd1, 4'd0);
		issue(KIND_INSERT, '1, 8'd2, 4'd0);
		issue(KIND_READ, '0, 8'd0, 4'd15);
		issue(KIND_READ, '0, 8'd0, 4'd0);
		// every delete hits a held key, so the table empties after one pass
		repeat (CAPACITY) begin
			next_slot();
			send_op(KIND_DELETE, held_key_any(), 8'($urandom()), 4'($urandom()));
		end
		issue(KIND_DELETE, name_pool[2], 8'd0, 4'd0);
		drain_wait();
	endtask

	// mostly well-formed traffic: deletes hit held keys, reads land inside the count;
	// fill and drain phases push the count across its whole range
	task automatic test_random_mix(int n_items);
		int r;
		int ins_pct;
		int del_pct;
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [RIDX_W-1:0] idx;
		for (int n = 0; n < n_items; n++) begin
			if (n % 300 == 299)
				drain_wait();
			ins_pct = ((n / 100) % 2 == 0) ? 60 : 25;
			del_pct = ((n / 100) % 2 == 0) ? 20 : 55;
			next_slot();
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				kind = KIND_INSERT;
			else if (r < ins_pct + del_pct)
				kind = KIND_DELETE;
			else if (r < 97)
				kind = KIND_READ;
			else
				kind = KIND_UNUSED;
			r = $urandom_range(0, 9);
			if (kind == KIND_DELETE) begin
				if (r < 7 && held_count > 0)
					key = held_key_any();
				else if (r < 9)
					key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					key = rand_key();
			end else begin
				if (r < 5)
					key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
				else if (r == 5 && held_count > 0)
					key = held_key_any();
				else
					key = rand_key();
			end
			if ($urandom_range(0, 4) != 0 && held_count > 0)
				idx = RIDX_W'($urandom_range(0, held_count - 1));
			else
				idx = RIDX_W'($urandom());
			send_op(kind, key, 8'($urandom()), idx);
		end
	endtask

	initial begin
		name_pool[0] = '0;
		name_pool[1] = pack_name("a");
		name_pool[2] = pack_name("alice");
		name_pool[3] = pack_name("alicia");
		name_pool[4] = pack_name("bob");
		name_pool[5] = pack_name("bobby");
		name_pool[6] = pack_name("carol");
		name_pool[7] = pack_name("zzzzzzzz");
		name_pool[8] = '1;
		for (int i = 0; i < 4; i++) begin
			kind_seen[i]   = 0;
			status_seen[i] = 0;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_order_and_duplicates();
		drain_wait();
		test_full_table();
		test_random_mix(1200);

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 64'(pending_results.size()), '0);

		$display("ran %0d inserts, %0d deletes, %0d reads, %0d unused-kind transactions",
			kind_seen[KIND_INSERT], kind_seen[KIND_DELETE], kind_seen[KIND_READ],
			kind_seen[KIND_UNUSED]);
		$display("saw %0d full rejects, %0d missing keys, %0d bad indexes, peak fill %0d, %0d errors",
			status_seen[ST_FULL], status_seen[ST_NOT_FOUND], status_seen[ST_BAD_INDEX],
			peak_count, error_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
